/* rtl/sah_pkg.sv */
// ----------------------------------------------------------------------------
// sah_pkg: shared definitions for the sampled address histogram
// Default sizes, field widths and operation codes used by the histogram
// top level.
// ----------------------------------------------------------------------------
package sah_pkg;

  // Default sizes of the histogram.
  localparam int BUCKETS_DEF   = 1024;
  localparam int SLOTS_DEF     = 16;
  localparam int SHIFT_DEF     = 4;
  localparam int TOP_COUNT_DEF = 8;

  // No report ever returns more than this many buckets.
  localparam int MAX_EMIT = 8;

  // Field widths.
  localparam int ADDR_BITS  = 32;
  localparam int COUNT_BITS = 32;
  localparam int SLOT_BITS  = 4;
  localparam int RANK_BITS  = 3;

  // Stream widths, whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 104;

  // Operation codes carried in the input tuser bit.
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

endpackage

/* rtl/sah_ram.sv */
// ----------------------------------------------------------------------------
// sah_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sah_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/sampled_address_histogram_top_n_top.sv */
// ----------------------------------------------------------------------------
// sampled_address_histogram_top_n_top: per-slot address sampling histogram
// Records sampled addresses into per-slot bucket tables and reports the
// hottest buckets of a slot in descending hit order, then clears that slot.
// ----------------------------------------------------------------------------
// A sample item walks the slot's bucket table through the single read port of
// the bucket memory, one entry per cycle, until it finds the sampled bucket or
// has read all used entries, where used is the number of buckets in that slot.
// A report item makes one full walk of the table per reported bucket and
// reports min(used, TOP_COUNT, 8) buckets; each result may wait for the output
// side. The block takes no new item while it is walking the table or emitting
// a result. The bucket memory needs no clearing after reset: only entries
// below a slot's fill count are ever read.
module sampled_address_histogram_top_n_top
  import sah_pkg::*;
#(
  parameter int BUCKETS   = BUCKETS_DEF,
  parameter int SLOTS     = SLOTS_DEF,
  parameter int SHIFT     = SHIFT_DEF,
  parameter int TOP_COUNT = TOP_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // thread_slot [3:0], sample_address [35:4], zero fill [39:36]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op [0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // bucket_address [31:0], hit_count [63:32], slot_samples [95:64],
  // rank [98:96], zero fill [103:99]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int KEY_W    = ADDR_BITS - SHIFT;
  localparam int IDX_W    = $clog2(BUCKETS);
  localparam int CNT_W    = $clog2(BUCKETS + 1);
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEPTH    = SLOTS * BUCKETS;
  localparam int MEM_AW   = $clog2(DEPTH);
  localparam int MEM_W    = KEY_W + COUNT_BITS;
  localparam int SHOW_MAX = (TOP_COUNT < MAX_EMIT) ? TOP_COUNT : MAX_EMIT;
  localparam int RNK_W    = 4;
  localparam int SEXT_W   = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PASS,
    ST_EMIT
  } state_t;

  state_t state;

  // Per-slot fill counts and sample totals.
  logic [CNT_W-1:0]      used_tab  [SLOTS];
  logic [COUNT_BITS-1:0] total_tab [SLOTS];

  // Item context.
  logic [SLOT_W-1:0]     slot;
  logic [MEM_AW-1:0]     base;
  logic [KEY_W-1:0]      key;
  logic [CNT_W-1:0]      used_cur;
  logic [COUNT_BITS-1:0] total_cur;

  // Table walk.
  logic [CNT_W-1:0]      rd_idx;
  logic                  pend;
  logic [IDX_W-1:0]      cmp_idx;

  // Top-n selection.
  logic [RNK_W-1:0]      shown;
  logic [RNK_W-1:0]      rnk;
  logic                  first_pass;
  logic                  found;
  logic [COUNT_BITS-1:0] best_hits;
  logic [IDX_W-1:0]      best_idx;
  logic [KEY_W-1:0]      best_key;
  logic [COUNT_BITS-1:0] prev_hits;
  logic [IDX_W-1:0]      prev_idx;

  // Output register.
  logic                  m_valid;
  logic [OUT_DATA_W-1:0] m_data;
  logic                  m_last;

  // Input decode.
  logic                  in_acc;
  op_t                   in_op;
  logic [SEXT_W-1:0]     slot_ext;
  logic                  slot_ok;
  logic [SLOT_W-1:0]     slot_in;
  logic [ADDR_BITS-1:0]  addr_in;
  logic [CNT_W-1:0]      used_in;

  // Memory ports.
  logic                  mem_wr_en;
  logic [MEM_AW-1:0]     mem_wr_addr;
  logic [MEM_W-1:0]      mem_wr_data;
  logic                  mem_rd_en;
  logic [MEM_AW-1:0]     mem_rd_addr;
  logic [MEM_W-1:0]      mem_rd_data;
  logic [KEY_W-1:0]      rd_key;
  logic [COUNT_BITS-1:0] rd_hits;

  // Walk control.
  logic                  issue;
  logic                  cmp_hit;
  logic                  scan_miss;
  logic                  has_room;
  logic                  pass_end;
  logic                  elig;
  logic                  take;
  logic                  out_free;
  logic [ADDR_BITS-1:0]  best_addr;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_op    = op_t'(s_axis_tuser);
  assign slot_ext = SEXT_W'(s_axis_tdata[SLOT_BITS-1:0]);
  assign slot_ok  = slot_ext < SEXT_W'(SLOTS);
  assign slot_in  = slot_ext[SLOT_W-1:0];
  assign addr_in  = s_axis_tdata[SLOT_BITS +: ADDR_BITS];
  assign used_in  = used_tab[slot_in];

  assign rd_key  = mem_rd_data[COUNT_BITS +: KEY_W];
  assign rd_hits = mem_rd_data[COUNT_BITS-1:0];

  assign issue     = ((state == ST_SCAN) || (state == ST_PASS)) && (rd_idx < used_cur);
  assign cmp_hit   = (state == ST_SCAN) && pend && (rd_key == key);
  assign scan_miss = (state == ST_SCAN) && !pend && !issue;
  assign has_room  = used_cur < CNT_W'(BUCKETS);
  assign pass_end  = (state == ST_PASS) && !pend && !issue;

  // An entry is still a candidate when it ranks after the previous pick:
  // fewer hits, or as many hits but inserted later.
  assign elig = first_pass || (rd_hits < prev_hits) ||
                ((rd_hits == prev_hits) && (cmp_idx > prev_idx));
  assign take = (state == ST_PASS) && pend && elig && (!found || (rd_hits > best_hits));

  assign out_free  = !m_valid || m_axis_tready;
  assign best_addr = ADDR_BITS'(best_key) << SHIFT;

  always_comb begin
    mem_rd_en   = issue;
    mem_rd_addr = base + MEM_AW'(rd_idx[IDX_W-1:0]);
    mem_wr_en   = cmp_hit || (scan_miss && has_room);
    if (cmp_hit) begin
      mem_wr_addr = base + MEM_AW'(cmp_idx);
      mem_wr_data = {rd_key, rd_hits + COUNT_BITS'(1)};
    end else begin
      mem_wr_addr = base + MEM_AW'(used_cur[IDX_W-1:0]);
      mem_wr_data = {key, COUNT_BITS'(1)};
    end
  end

  sah_ram #(
    .WIDTH (MEM_W),
    .DEPTH (DEPTH)
  ) u_bucket_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
      pend    <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        used_tab[s]  <= '0;
        total_tab[s] <= '0;
      end
    end else begin
      if (m_valid && m_axis_tready) begin
        m_valid <= 1'b0;
      end

      if (issue) begin
        rd_idx  <= rd_idx + CNT_W'(1);
        cmp_idx <= rd_idx[IDX_W-1:0];
      end
      pend <= issue;

      if (take) begin
        found     <= 1'b1;
        best_hits <= rd_hits;
        best_idx  <= cmp_idx;
        best_key  <= rd_key;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc && slot_ok) begin
            slot       <= slot_in;
            base       <= MEM_AW'(slot_in * BUCKETS);
            key        <= addr_in[ADDR_BITS-1:SHIFT];
            used_cur   <= used_in;
            total_cur  <= total_tab[slot_in];
            rd_idx     <= '0;
            pend       <= 1'b0;
            first_pass <= 1'b1;
            found      <= 1'b0;
            rnk        <= '0;
            shown      <= (used_in < CNT_W'(SHOW_MAX)) ? RNK_W'(used_in) : RNK_W'(SHOW_MAX);
            if (in_op == OP_SAMPLE) begin
              if (addr_in != '0) begin
                total_tab[slot_in] <= total_tab[slot_in] + COUNT_BITS'(1);
                state              <= ST_SCAN;
              end
            end else if (total_tab[slot_in] != '0) begin
              if (used_in == '0) begin
                total_tab[slot_in] <= '0;
              end else begin
                state <= ST_PASS;
              end
            end
          end
        end

        ST_SCAN: begin
          if (cmp_hit) begin
            state <= ST_IDLE;
          end else if (scan_miss) begin
            if (has_room) begin
              used_tab[slot] <= used_cur + CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end

        ST_PASS: begin
          if (pass_end) begin
            state <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            m_valid <= 1'b1;
            m_data  <= {(OUT_DATA_W - 3 * COUNT_BITS - RANK_BITS)'(0),
                        rnk[RANK_BITS-1:0], total_cur, best_hits, best_addr};
            m_last  <= (rnk + RNK_W'(1)) == shown;
            if ((rnk + RNK_W'(1)) == shown) begin
              used_tab[slot]  <= '0;
              total_tab[slot] <= '0;
              state           <= ST_IDLE;
            end else begin
              rnk        <= rnk + RNK_W'(1);
              prev_hits  <= best_hits;
              prev_idx   <= best_idx;
              first_pass <= 1'b0;
              found      <= 1'b0;
              rd_idx     <= '0;
              pend       <= 1'b0;
              state      <= ST_PASS;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;
  assign m_axis_tlast  = m_last;

endmodule
